// ----- design/lfp_pkg.sv -----
// Shared constants and types for the line-follow PID step block.
package lfp_pkg;

  // Field widths
  localparam int POS_W    = 12;
  localparam int SENSOR_W = 10;
  localparam int POWER_W  = 8;
  localparam int CFG_W    = 10;
  localparam int ERR_W    = 13;
  localparam int DERIV_W  = 14;
  localparam int SUM_W    = 32;
  localparam int DTERM_W  = 15;
  localparam int DIFF_W   = 20;

  // Divider operand and quotient widths
  localparam int PMAG_W = 10;   // |error| / 4
  localparam int IMAG_W = 28;   // |sum| / 16
  localparam int PQ_W   = 7;    // |error| / 20
  localparam int IQ_W   = 18;   // |sum| / 10000

  localparam logic [ERR_W-1:0] CENTRE_OFFSET = 13'd1900;

  // x / 5 for x < 2**10: (x * 1639) >> 13
  localparam logic [10:0] P_RECIP = 11'd1639;
  localparam int          P_SHIFT = 13;
  // x / 625 for x < 2**28: (x * 439804652) >> 38
  localparam logic [28:0] I_RECIP = 29'd439804652;
  localparam int          I_SHIFT = 38;

  localparam logic [SUM_W-1:0] SUM_MAX = 32'h7FFF_FFFF;
  localparam logic [SUM_W-1:0] SUM_MIN = 32'h8000_0000;

  localparam logic [POWER_W-1:0]  MAX_POWER_RST      = 8'd60;
  localparam logic [SENSOR_W-1:0] LINE_THRESHOLD_RST = 10'd350;

  typedef enum logic [0:0] {
    REG_MAX_POWER      = 1'b0,
    REG_LINE_THRESHOLD = 1'b1
  } cfg_reg_t;

endpackage

// ----- design/lfp_const_div.sv -----
// Constant divisions for the proportional and integral terms by reciprocal multiply.
module lfp_const_div (
  input  logic [lfp_pkg::PMAG_W-1:0] err_mag4,
  input  logic [lfp_pkg::IMAG_W-1:0] sum_mag4,
  output logic [lfp_pkg::PQ_W-1:0]   p_quot,
  output logic [lfp_pkg::IQ_W-1:0]   i_quot
);

  logic [20:0] p_prod;
  logic [56:0] i_prod;

  assign p_prod = 21'(err_mag4) * 21'(lfp_pkg::P_RECIP);
  assign i_prod = 57'(sum_mag4) * 57'(lfp_pkg::I_RECIP);

  assign p_quot = p_prod[lfp_pkg::P_SHIFT +: lfp_pkg::PQ_W];
  assign i_quot = i_prod[lfp_pkg::I_SHIFT +: lfp_pkg::IQ_W];

endmodule

// ----- design/line_follow_pid_step.sv -----
// Top level of the line-follow PID step: pipeline, kept state and configuration.
// Takes one sensor sample per cycle while the output side does not stall and returns
// one drive command per sample, five register stages deep. The error and saturating
// error sum are updated as a sample leaves the input register, in a single 33-bit add
// saturated to 32 bits, so consecutive samples follow with no gap; the term divisions
// by 20 and 10000 are reciprocal multiplies in a later stage. Each stage holds its
// item while the next is full, so requests keep being taken while a result waits,
// until every stage is full. Write max_power and line_threshold only while the
// block is empty.
module line_follow_pid_step (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [0:0]                       cfg_index,
  input  logic [lfp_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lfp_pkg::POS_W-1:0]        line_position,
  input  logic [lfp_pkg::SENSOR_W-1:0]     sensor_far_left,
  input  logic [lfp_pkg::SENSOR_W-1:0]     sensor_left,
  input  logic [lfp_pkg::SENSOR_W-1:0]     sensor_centre,
  input  logic [lfp_pkg::SENSOR_W-1:0]     sensor_right,
  input  logic [lfp_pkg::SENSOR_W-1:0]     sensor_far_right,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lfp_pkg::POWER_W-1:0]      left_drive,
  output logic [lfp_pkg::POWER_W-1:0]      right_drive,
  output logic                             dead_end,
  output logic                             junction
);

  // Configuration
  logic [lfp_pkg::POWER_W-1:0]  max_power;
  logic [lfp_pkg::SENSOR_W-1:0] line_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_power      <= lfp_pkg::MAX_POWER_RST;
      line_threshold <= lfp_pkg::LINE_THRESHOLD_RST;
    end else if (cfg_write) begin
      case (lfp_pkg::cfg_reg_t'(cfg_index))
        lfp_pkg::REG_MAX_POWER:      max_power      <= cfg_data[lfp_pkg::POWER_W-1:0];
        lfp_pkg::REG_LINE_THRESHOLD: line_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valids and per-stage ready chain
  logic v0, v1, v2, v3;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign in_ready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy0) v0 <= in_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) out_valid <= v3;
    end
  end

  // Stage 0: input register
  logic [lfp_pkg::POS_W-1:0]    pos0;
  logic [lfp_pkg::SENSOR_W-1:0] s0_0, s1_0, s2_0, s3_0, s4_0;

  always_ff @(posedge clk) begin
    if (in_valid && rdy0) begin
      pos0 <= line_position;
      s0_0 <= sensor_far_left;
      s1_0 <= sensor_left;
      s2_0 <= sensor_centre;
      s3_0 <= sensor_right;
      s4_0 <= sensor_far_right;
    end
  end

  // Stage 1: error, derivative, saturating sum, flags; kept state advances here
  logic signed [lfp_pkg::ERR_W-1:0]   previous_error;
  logic signed [lfp_pkg::SUM_W-1:0]   error_sum;
  logic signed [lfp_pkg::ERR_W-1:0]   err_next;
  logic signed [lfp_pkg::DERIV_W-1:0] deriv_next;
  logic        [lfp_pkg::SUM_W:0]     sum_wide;
  logic signed [lfp_pkg::SUM_W-1:0]   sum_next;
  logic                               dead_next, junc_next;
  logic                               adv1;

  assign err_next   = $signed({1'b0, pos0} - lfp_pkg::CENTRE_OFFSET);
  assign deriv_next = $signed({err_next[lfp_pkg::ERR_W-1], err_next})
                    - $signed({previous_error[lfp_pkg::ERR_W-1], previous_error});
  assign sum_wide   = {error_sum[lfp_pkg::SUM_W-1], error_sum}
                    + {{(lfp_pkg::SUM_W-lfp_pkg::ERR_W+1){err_next[lfp_pkg::ERR_W-1]}},
                       err_next};

  always_comb begin
    if (sum_wide[lfp_pkg::SUM_W] != sum_wide[lfp_pkg::SUM_W-1]) begin
      sum_next = sum_wide[lfp_pkg::SUM_W] ? $signed(lfp_pkg::SUM_MIN)
                                          : $signed(lfp_pkg::SUM_MAX);
    end else begin
      sum_next = $signed(sum_wide[lfp_pkg::SUM_W-1:0]);
    end
  end

  assign dead_next = (s1_0 < line_threshold) && (s2_0 < line_threshold)
                  && (s3_0 < line_threshold);
  assign junc_next = !dead_next && ((s0_0 > line_threshold) || (s4_0 > line_threshold));
  assign adv1      = v0 && rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      error_sum      <= '0;
    end else if (adv1) begin
      // a dead end or junction restarts the controller
      previous_error <= (dead_next || junc_next) ? '0 : err_next;
      error_sum      <= (dead_next || junc_next) ? '0 : sum_next;
    end
  end

  logic signed [lfp_pkg::ERR_W-1:0]   err1;
  logic signed [lfp_pkg::DERIV_W-1:0] deriv1;
  logic signed [lfp_pkg::SUM_W-1:0]   sum1;
  logic                               dead1, junc1;

  always_ff @(posedge clk) begin
    if (adv1) begin
      err1   <= err_next;
      deriv1 <= deriv_next;
      sum1   <= sum_next;
      dead1  <= dead_next;
      junc1  <= junc_next;
    end
  end

  // Stage 2: magnitudes for the divisions, derivative term
  logic [lfp_pkg::SUM_W-1:0]          sum_mag;
  logic [lfp_pkg::ERR_W-1:0]          err_mag;
  logic signed [15:0]                 deriv3;
  logic signed [15:0]                 deriv3_half;

  assign sum_mag     = sum1[lfp_pkg::SUM_W-1] ? (~sum1 + 1'b1) : sum1;
  assign err_mag     = err1[lfp_pkg::ERR_W-1] ? (~err1 + 1'b1) : err1;
  assign deriv3      = $signed({{2{deriv1[lfp_pkg::DERIV_W-1]}}, deriv1})
                     + $signed({deriv1[lfp_pkg::DERIV_W-1], deriv1, 1'b0});
  // round toward zero before halving
  assign deriv3_half = (deriv3 + $signed({15'd0, deriv3[15]})) >>> 1;

  logic                               sum_neg2, err_neg2, dead2, junc2;
  logic [lfp_pkg::IMAG_W-1:0]         sum_mag4;
  logic [lfp_pkg::PMAG_W-1:0]         err_mag4;
  logic signed [lfp_pkg::DTERM_W-1:0] dterm2;

  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      sum_neg2 <= sum1[lfp_pkg::SUM_W-1];
      err_neg2 <= err1[lfp_pkg::ERR_W-1];
      sum_mag4 <= sum_mag[lfp_pkg::SUM_W-1:4];
      err_mag4 <= err_mag[lfp_pkg::ERR_W-2:2];
      dterm2   <= deriv3_half[lfp_pkg::DTERM_W-1:0];
      dead2    <= dead1;
      junc2    <= junc1;
    end
  end

  // Stage 3: reciprocal multiplies
  logic [lfp_pkg::PQ_W-1:0] p_quot;
  logic [lfp_pkg::IQ_W-1:0] i_quot;

  lfp_const_div u_div (
    .err_mag4 (err_mag4),
    .sum_mag4 (sum_mag4),
    .p_quot   (p_quot),
    .i_quot   (i_quot)
  );

  logic                               sum_neg3, err_neg3, dead3, junc3;
  logic [lfp_pkg::PQ_W-1:0]           p_quot3;
  logic [lfp_pkg::IQ_W-1:0]           i_quot3;
  logic signed [lfp_pkg::DTERM_W-1:0] dterm3;

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      sum_neg3 <= sum_neg2;
      err_neg3 <= err_neg2;
      p_quot3  <= p_quot;
      i_quot3  <= i_quot;
      dterm3   <= dterm2;
      dead3    <= dead2;
      junc3    <= junc2;
    end
  end

  // Stage 4: sum the terms, clamp, split across the wheels
  logic signed [lfp_pkg::DIFF_W-1:0] pterm, iterm, dterm, diff, diff_clamped, lim;
  logic signed [lfp_pkg::DIFF_W-1:0] left_full, right_full;

  assign pterm = err_neg3 ? -$signed(lfp_pkg::DIFF_W'(p_quot3))
                          :  $signed(lfp_pkg::DIFF_W'(p_quot3));
  assign iterm = sum_neg3 ? -$signed(lfp_pkg::DIFF_W'(i_quot3))
                          :  $signed(lfp_pkg::DIFF_W'(i_quot3));
  assign dterm = $signed({{(lfp_pkg::DIFF_W-lfp_pkg::DTERM_W){dterm3[lfp_pkg::DTERM_W-1]}},
                          dterm3});
  assign diff  = pterm + iterm + dterm;
  assign lim   = $signed(lfp_pkg::DIFF_W'(max_power));

  always_comb begin
    diff_clamped = diff;
    if (diff > lim) diff_clamped = lim;
    if (diff < -lim) diff_clamped = -lim;
    if (diff_clamped < 0) begin
      left_full  = lim + diff_clamped;
      right_full = lim;
    end else begin
      left_full  = lim;
      right_full = lim - diff_clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && rdy4) begin
      left_drive  <= left_full[lfp_pkg::POWER_W-1:0];
      right_drive <= right_full[lfp_pkg::POWER_W-1:0];
      dead_end    <= dead3;
      junction    <= junc3;
    end
  end

endmodule
